>>> rtl/stpm_pkg.sv
// ----------------------------------------------------------------------------
// stpm_pkg
// Shared types, register codes and constants of the speaker toggle to PCM
// mixer: item structs, command and operation codes, ring entry codes.
// ----------------------------------------------------------------------------
`default_nettype none

package stpm_pkg;

	// default geometry of the sample ring
	localparam int RING_DEPTH_DEF = 8192;
	localparam int PLAY_LAG_DEF   = 512;

	// fill count width covers the largest allowed lag
	localparam int FILL_CNT_W = 13;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// register reset values
	localparam logic [31:0] SPC_RST    = 32'd708;
	localparam logic [7:0]  SCALE_RST  = 8'd96;
	localparam logic [7:0]  GAIN_RST   = 8'd255;
	localparam logic        MIX_EN_RST = 1'b0;

	// entries of the front-to-back queue
	localparam int Q_DEPTH = 4;

	typedef enum logic [1:0] {
		CMD_TOGGLE = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_RESYNC = 2'd2,
		CMD_LATCH  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_SPC    = 2'd0,
		REG_SCALE  = 2'd1,
		REG_GAIN   = 2'd2,
		REG_MIX_EN = 2'd3
	} cfg_reg_t;

	// ring entries only ever hold 0, + or - codes, read out as 0 or +/- scale * 256
	typedef logic [1:0] ring_code_t;
	localparam ring_code_t RC_ZERO = 2'b00;
	localparam ring_code_t RC_POS  = 2'b01;
	localparam ring_code_t RC_NEG  = 2'b11;

	typedef struct packed {
		cmd_t               command;
		logic [47:0]        cycle;
		logic signed [15:0] mix_left_in;
		logic signed [15:0] mix_right_in;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic signed [15:0] speaker_level;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_FILL   = 3'd0,
		OP_JUMP   = 3'd1,
		OP_TICK   = 3'd2,
		OP_RESYNC = 3'd3,
		OP_LATCH  = 3'd4
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [FILL_CNT_W-1:0] count;
		logic                  high;
		logic signed [15:0]    mix_left;
		logic signed [15:0]    mix_right;
	} q_entry_t;

	typedef struct packed {
		logic clearing;
		logic out_load;
	} bk_stat_t;

	typedef enum logic [1:0] {
		F_IDLE  = 2'd0,
		F_MUL   = 2'd1,
		F_CLASS = 2'd2,
		F_PUSH  = 2'd3
	} front_state_t;

	typedef enum logic [2:0] {
		B_CLEAR  = 3'd0,
		B_IDLE   = 3'd1,
		B_FILL   = 3'd2,
		B_TICK_A = 3'd3,
		B_TICK_B = 3'd4
	} back_state_t;

endpackage

`default_nettype wire

>>> rtl/stpm_ram.sv
// ----------------------------------------------------------------------------
// stpm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stpm_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/stpm_front.sv
// ----------------------------------------------------------------------------
// stpm_front
// Takes items, maps toggle and resync cycles to ring positions with a
// 48x32 multiply in three 16-bit slices, classifies each item and hands an
// operation to the back part through the queue, except toggles that do not advance.
// ----------------------------------------------------------------------------
`default_nettype none

module stpm_front
	import stpm_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int PLAY_LAG   = PLAY_LAG_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire in_item_t    in_item,
	input  wire logic        hold,
	input  wire logic [31:0] spc,
	input  wire logic        q_full,
	output logic             full,
	output logic             q_push,
	output q_entry_t         q_data
);

	front_state_t state_q, state_d;
	logic [1:0]   step_q;
	logic [63:0]  last_q;
	logic         high_q;
	in_item_t     item_q;
	logic [63:0]  acc_q;
	logic [47:0]  pp_q;
	q_entry_t     ent_q;

	logic                  accept;
	logic [15:0]           chunk;
	logic [47:0]           pp_d;
	logic [63:0]           add_term;
	logic [48:0]           diff;
	logic                  is_back;
	logic                  is_jump;
	logic [FILL_CNT_W-1:0] fill_cnt;

	assign accept = push && !full;

	// slice of the cycle for this multiply step
	always_comb begin
		case (step_q)
			2'd0:    chunk = item_q.cycle[15:0];
			2'd1:    chunk = item_q.cycle[31:16];
			2'd2:    chunk = item_q.cycle[47:32];
			default: chunk = 16'd0;
		endcase
	end

	assign pp_d = chunk * spc;

	// previous partial product aligned to its slice, kept to 64 bits
	always_comb begin
		case (step_q)
			2'd1:    add_term = {16'd0, pp_q};
			2'd2:    add_term = {pp_q, 16'd0};
			2'd3:    add_term = {pp_q[31:0], 32'd0};
			default: add_term = 64'd0;
		endcase
	end

	// position advance against the last recorded position
	assign diff    = {1'b0, acc_q[63:16]} - {1'b0, last_q[63:16]};
	assign is_back = (diff == 49'd0) || diff[48];
	assign is_jump = diff > 49'(PLAY_LAG);
	assign fill_cnt = (diff > 49'(RING_DEPTH)) ? FILL_CNT_W'(RING_DEPTH)
		: diff[FILL_CNT_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (in_item.command inside {CMD_TOGGLE, CMD_RESYNC}) begin
						state_d = F_MUL;
					end else begin
						state_d = F_PUSH;
					end
				end
			end
			F_MUL: begin
				if (step_q == 2'd3) begin
					state_d = F_CLASS;
				end
			end
			F_CLASS: begin
				if (item_q.command == CMD_TOGGLE && is_back) begin
					state_d = F_IDLE;
				end else begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		full   = (state_q != F_IDLE) || hold;
		q_push = (state_q == F_PUSH);
		q_data = ent_q;
	end

	// control state and position tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
			last_q  <= '0;
			high_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == F_MUL) begin
				step_q <= step_q + 2'd1;
			end else begin
				step_q <= '0;
			end
			if (state_q == F_CLASS) begin
				if (item_q.command == CMD_RESYNC) begin
					last_q <= acc_q;
					high_q <= 1'b1;
				end else if (is_back) begin
					high_q <= ~high_q;
				end else begin
					last_q <= acc_q;
					high_q <= ~high_q;
				end
			end
		end
	end

	// item, product and queue entry
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q          <= in_item;
			acc_q           <= '0;
			ent_q.op        <= (in_item.command == CMD_TICK) ? OP_TICK : OP_LATCH;
			ent_q.count     <= '0;
			ent_q.high      <= 1'b0;
			ent_q.mix_left  <= in_item.mix_left_in;
			ent_q.mix_right <= in_item.mix_right_in;
		end
		if (state_q == F_MUL) begin
			if (step_q != 2'd3) begin
				pp_q <= pp_d;
			end
			if (step_q != 2'd0) begin
				acc_q <= acc_q + add_term;
			end
		end
		if (state_q == F_CLASS) begin
			if (item_q.command == CMD_RESYNC) begin
				ent_q.op <= OP_RESYNC;
			end else if (is_jump) begin
				ent_q.op <= OP_JUMP;
			end else begin
				ent_q.op <= OP_FILL;
			end
			ent_q.count <= fill_cnt;
			ent_q.high  <= high_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/stpm_queue.sv
// ----------------------------------------------------------------------------
// stpm_queue
// Short flop-based queue of operations between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module stpm_queue
	import stpm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr,
	input  wire q_entry_t wdata,
	input  wire logic     rd,
	output logic          full,
	output logic          empty,
	output q_entry_t      rdata
);

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	q_entry_t        ent_q [Q_DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = (cnt_q == CW'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = ent_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wp_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> rtl/stpm_back.sv
// ----------------------------------------------------------------------------
// stpm_back
// Carries out queued operations on the sample ring: fills, pointer jumps,
// clearing sweeps, mix latches, reads for output samples, scaling, mixing
// and saturation. Holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stpm_back
	import stpm_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int PLAY_LAG   = PLAY_LAG_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_empty,
	input  wire q_entry_t   q_data,
	output logic            q_pop,
	input  wire logic [7:0] scale,
	input  wire logic [7:0] gain,
	input  wire logic       mix_en,
	input  wire logic       pop,
	output logic            out_valid,
	output out_item_t       out_item,
	output bk_stat_t        stat
);

	localparam int AW      = $clog2(RING_DEPTH);
	localparam int LAG_MOD = PLAY_LAG % RING_DEPTH;

	back_state_t           state_q, state_d;
	logic [AW-1:0]         wp_q;
	logic [AW-1:0]         rp_q;
	logic [AW-1:0]         clr_q;
	logic [FILL_CNT_W-1:0] cnt_q;
	ring_code_t            val_q;
	ring_code_t            held_q;
	logic signed [15:0]    mix_l_q;
	logic signed [15:0]    mix_r_q;
	logic signed [24:0]    prod_l_s1;
	logic signed [24:0]    prod_r_s1;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	ring_code_t            ram_wdata;
	ring_code_t            ram_rdata;
	logic [AW-1:0]         wp_inc;
	logic [AW-1:0]         rp_inc;
	logic [AW:0]           jump_sum;
	logic [AW-1:0]         jump_wp;
	logic                  ring_nonempty;
	logic                  out_load;
	ring_code_t            contrib;
	logic signed [16:0]    scale256;
	logic signed [16:0]    level;
	logic signed [24:0]    adj_l;
	logic signed [24:0]    adj_r;
	logic signed [16:0]    div_l;
	logic signed [16:0]    div_r;
	logic signed [17:0]    sum_l;
	logic signed [17:0]    sum_r;
	logic signed [24:0]    prod_l_d;
	logic signed [24:0]    prod_r_d;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	stpm_ram #(
		.WIDTH ($bits(ring_code_t)),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	// pointer arithmetic with wrap at the ring depth
	assign wp_inc   = (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc   = (rp_q == AW'(RING_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign jump_sum = {1'b0, rp_q} + (AW + 1)'(LAG_MOD);
	assign jump_wp  = (jump_sum >= (AW + 1)'(RING_DEPTH))
		? AW'(jump_sum - (AW + 1)'(RING_DEPTH)) : jump_sum[AW-1:0];

	assign ring_nonempty = (wp_q != rp_q);
	assign out_load      = (state_q == B_TICK_B) && (!out_valid_q || pop);

	// mix products, registered before the add
	assign prod_l_d = mix_l_q * $signed({1'b0, gain});
	assign prod_r_d = mix_r_q * $signed({1'b0, gain});

	// output sample: scale, divide mix by 256 toward zero, add, saturate
	always_comb begin
		contrib  = ring_nonempty ? ram_rdata : held_q;
		scale256 = $signed({1'b0, scale, 8'd0});
		case (contrib)
			RC_POS:  level = scale256;
			RC_NEG:  level = -scale256;
			default: level = 17'sd0;
		endcase
		adj_l = prod_l_s1 + $signed({17'd0, {8{prod_l_s1[24]}}});
		adj_r = prod_r_s1 + $signed({17'd0, {8{prod_r_s1[24]}}});
		div_l = adj_l[24:8];
		div_r = adj_r[24:8];
		sum_l = {level[16], level};
		sum_r = {level[16], level};
		if (mix_en) begin
			sum_l = sum_l + {div_l[16], div_l};
			sum_r = sum_r + {div_r[16], div_r};
		end
	end

	// ring write port: clearing sweep, fill, or clear after read
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = RC_ZERO;
		case (state_q)
			B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			B_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = val_q;
			end
			B_TICK_B: begin
				ram_we    = out_load && ring_nonempty;
				ram_waddr = rp_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_q == AW'(RING_DEPTH - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (!q_empty) begin
					case (q_data.op)
						OP_FILL:   state_d = B_FILL;
						OP_TICK:   state_d = B_TICK_A;
						OP_RESYNC: state_d = B_CLEAR;
						default:   state_d = B_IDLE;
					endcase
				end
			end
			B_FILL: begin
				if (cnt_q == FILL_CNT_W'(1)) begin
					state_d = B_IDLE;
				end
			end
			B_TICK_A: state_d = B_TICK_B;
			B_TICK_B: begin
				if (out_load) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop         = (state_q == B_IDLE) && !q_empty;
		out_valid     = out_valid_q;
		out_item      = out_q;
		stat.clearing = (state_q == B_CLEAR);
		stat.out_load = out_load;
	end

	// control state, pointers and latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			wp_q        <= AW'(LAG_MOD);
			rp_q        <= '0;
			held_q      <= RC_ZERO;
			mix_l_q     <= '0;
			mix_r_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end else begin
				clr_q <= '0;
			end
			if (q_pop) begin
				case (q_data.op)
					OP_JUMP: wp_q <= jump_wp;
					OP_RESYNC: begin
						wp_q <= AW'(LAG_MOD);
						rp_q <= '0;
					end
					OP_LATCH: begin
						mix_l_q <= q_data.mix_left;
						mix_r_q <= q_data.mix_right;
					end
					default: ;
				endcase
			end
			// fill one entry, pushing the read pointer on overrun
			if (state_q == B_FILL) begin
				wp_q <= wp_inc;
				if (wp_inc == rp_q) begin
					rp_q <= rp_inc;
				end
			end
			if (out_load && ring_nonempty) begin
				rp_q   <= rp_inc;
				held_q <= ram_rdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// fill job and datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cnt_q <= q_data.count;
			val_q <= q_data.high ? RC_POS : RC_NEG;
		end else if (state_q == B_FILL) begin
			cnt_q <= cnt_q - 1'b1;
		end
		if (state_q == B_TICK_A) begin
			prod_l_s1 <= prod_l_d;
			prod_r_s1 <= prod_r_d;
		end
		if (out_load) begin
			out_q.left_out      <= sat16(sum_l);
			out_q.right_out     <= sat16(sum_r);
			out_q.speaker_level <= sat16({level[16], level});
		end
	end

endmodule

`default_nettype wire

>>> rtl/speaker_toggle_to_pcm_mixer.sv
// ----------------------------------------------------------------------------
// speaker_toggle_to_pcm_mixer
// Turns timestamped one-bit speaker toggles into PCM samples through a ring
// of per-sample contributions, with optional mixing of a second source.
//
//   channel   direction  handshake           payload
//   input     in         push / full         in_item  (in_item_t)
//   result    out        empty / pop         out_item (out_item_t)
//   config    in         cfg_we              cfg_index, cfg_data
//
// Toggle and resync pass the front (three-slice position multiply, classify);
// for a toggle the back then writes one ring entry per cycle of the advance
// through the single ring write port, up to the lag per toggle.
// Sample request: in the back a queue pop, a registered ring read and the mix
// add, plus any wait on a result not yet taken.
// Resync clears the whole ring; after reset the same clearing pass runs and
// full stays high while it runs.
// The front and back stall separately across a 4-entry queue; one result
// waits in the output register while new items are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module speaker_toggle_to_pcm_mixer
	import stpm_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	parameter int PLAY_LAG   = PLAY_LAG_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire in_item_t              in_item,
	output logic                       empty,
	input  wire logic                  pop,
	output out_item_t                  out_item,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [31:0] spc_q;
	logic [7:0]  scale_q;
	logic [7:0]  gain_q;
	logic        mix_en_q;

	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	q_entry_t    q_wdata;
	q_entry_t    q_rdata;
	bk_stat_t    bstat;
	logic        out_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spc_q    <= SPC_RST;
			scale_q  <= SCALE_RST;
			gain_q   <= GAIN_RST;
			mix_en_q <= MIX_EN_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SPC:    spc_q    <= cfg_data[31:0];
				REG_SCALE:  scale_q  <= cfg_data[7:0];
				REG_GAIN:   gain_q   <= cfg_data[7:0];
				REG_MIX_EN: mix_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item intake and classification
	stpm_front #(
		.RING_DEPTH (RING_DEPTH),
		.PLAY_LAG   (PLAY_LAG)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_item (in_item),
		.hold    (bstat.clearing),
		.spc     (spc_q),
		.q_full  (q_full),
		.full    (full),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	// operation queue
	stpm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.rd     (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	// ring execution and output
	stpm_back #(
		.RING_DEPTH (RING_DEPTH),
		.PLAY_LAG   (PLAY_LAG)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.scale     (scale_q),
		.gain      (gain_q),
		.mix_en    (mix_en_q),
		.pop       (pop),
		.out_valid (out_valid),
		.out_item  (out_item),
		.stat      (bstat)
	);

	assign empty = !out_valid;

	// no operation leaves the queue during a clearing sweep
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !bstat.clearing)
		else $error("queue popped during ring clearing");

	// a new result never overwrites one that was not taken
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		bstat.out_load |-> (empty || pop))
		else $error("result loaded over a waiting result");

	// the front takes one item at a time
	a_one_item_in_front: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full)
		else $error("front accepted back-to-back items");

endmodule

`default_nettype wire
